// File: hw/rtl/iumrg_pkg.sv
// Interval union merger: shared types and constants.
// No dependencies.
package iumrg_pkg;

  localparam int unsigned PosW  = 13;
  localparam int unsigned DataW = 32;

  typedef logic [PosW-1:0] pos_t;

  // one stored interval
  typedef struct packed {
    logic vld;
    pos_t b;
    pos_t e;
  } ival_t;

  // chain control, same for every cell
  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctl_t;

endpackage

// File: hw/rtl/iumrg_cell.sv
// Interval union merger: one cell of the sorted interval chain.
// Depends on iumrg_pkg.
module iumrg_cell
  import iumrg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  ival_t     new_ival,
  input  ival_t     left,
  input  logic      left_place,
  input  ival_t     right,
  output logic      place,
  output ival_t     ent
);

  logic vld;
  pos_t b;
  pos_t e;

  // new interval belongs at or before this cell
  assign place = !vld || (new_ival.b < b);
  assign ent   = '{vld: vld, b: b, e: e};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctl.shift) begin
      vld <= right.vld;
    end else if (ctl.ins && place) begin
      vld <= left_place ? left.vld : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      b <= right.b;
      e <= right.e;
    end else if (ctl.ins && place) begin
      b <= left_place ? left.b : new_ival.b;
      e <= left_place ? left.e : new_ival.e;
    end
  end

endmodule

// File: hw/rtl/iumrg_merge.sv
// Interval union merger: drains the chain head, merges touching intervals
// into runs and drives the output register. Depends on iumrg_pkg.
module iumrg_merge
  import iumrg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  ival_t            head,
  output logic             shift,
  output logic             busy,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [DataW-1:0] m_tdata,   // run_begin[12:0], run_end[25:13], zeros
  output logic             m_tlast    // last_run
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic state, state_next;
  logic pv, pv_next;
  pos_t rb, rb_next, re, re_next;
  logic ov, ov_next, ol, ol_next;
  pos_t ob, ob_next, oe, oe_next;
  logic out_free;
  logic touch;

  assign out_free = !ov || m_tready;
  assign touch    = {1'b0, head.b} <= ({1'b0, re} + (PosW+1)'(1));

  always_comb begin
    state_next = state;
    pv_next    = pv;
    rb_next    = rb;
    re_next    = re;
    ov_next    = ov && !m_tready;
    ob_next    = ob;
    oe_next    = oe;
    ol_next    = ol;
    shift      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (head.vld) begin
          if (!pv) begin
            pv_next = 1'b1;
            rb_next = head.b;
            re_next = head.e;
            shift   = 1'b1;
          end else if (touch) begin
            if (head.e > re) begin
              re_next = head.e;
            end
            shift = 1'b1;
          end else if (out_free) begin
            ov_next = 1'b1;
            ob_next = rb;
            oe_next = re;
            ol_next = 1'b0;
            rb_next = head.b;
            re_next = head.e;
            shift   = 1'b1;
          end
        end else if (pv) begin
          if (out_free) begin
            ov_next    = 1'b1;
            ob_next    = rb;
            oe_next    = re;
            ol_next    = 1'b1;
            pv_next    = 1'b0;
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pv    <= 1'b0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      pv    <= pv_next;
      ov    <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    rb <= rb_next;
    re <= re_next;
    ob <= ob_next;
    oe <= oe_next;
    ol <= ol_next;
  end

  assign busy     = (state == ST_DRAIN);
  assign m_tvalid = ov;
  assign m_tdata  = {{(DataW-2*PosW){1'b0}}, oe, ob};
  assign m_tlast  = ol;

  a_shift_drain: assert property (@(posedge clk) disable iff (rst)
    shift |-> state == ST_DRAIN) else $error("chain shifted outside drain");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == ST_IDLE) else $error("list end taken during drain");

  a_start_drain: assert property (@(posedge clk) disable iff (rst)
    start |=> state == ST_DRAIN) else $error("drain not entered");

  a_run_order: assert property (@(posedge clk) disable iff (rst)
    pv |-> rb <= re) else $error("pending run reversed");

  a_no_pend_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pv) else $error("run left pending in idle");

endmodule

// File: hw/rtl/interval_union_merger_top.sv
// Interval union merger top level: input clean-up, item count, chain of
// sorted interval cells and the run merger. Depends on iumrg_pkg,
// iumrg_cell and iumrg_merge.
//
//  channel | dir | tdata                              | tlast
//  s_      | in  | interval_begin[12:0], end[25:13]   | last_interval
//  m_      | out | run_begin[12:0], run_end[25:13]    | last_run
//
// An interval is taken and inserted in sorted place along the chain of
// MAX_INTERVALS cells, which holds at most MAX_INTERVALS intervals. After
// the word flagged last, the chain drains one cell a cycle into the merger,
// except while a finished run waits for the output register; s_tready
// stays low while the drain lasts.
// Reset empties the chain at once.
module interval_union_merger_top
  import iumrg_pkg::*;
#(
  parameter int unsigned POSITIONS     = 4096,
  parameter int unsigned MAX_INTERVALS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [DataW-1:0] s_tdata,   // interval_begin[12:0], interval_end[25:13], zeros
  input  logic             s_tlast,   // last_interval
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [DataW-1:0] m_tdata,   // run_begin[12:0], run_end[25:13], zeros
  output logic             m_tlast    // last_run
);

  localparam int unsigned CntW = $clog2(MAX_INTERVALS + 1);

  logic            acc;
  logic            busy;
  logic            shift;
  logic            start;
  logic            room;
  logic            ok;
  pos_t            in_b, in_e, b_adj, e_adj;
  logic [CntW-1:0] cnt;
  cell_ctl_t       ctl;
  ival_t           new_ival;
  ival_t           ent   [MAX_INTERVALS];
  logic            place [MAX_INTERVALS];

  assign in_b  = s_tdata[PosW-1:0];
  assign in_e  = s_tdata[2*PosW-1:PosW];
  assign b_adj = (in_b == '0) ? PosW'(1) : in_b;
  assign e_adj = (32'(in_e) > POSITIONS) ? PosW'(POSITIONS) : in_e;
  assign ok    = e_adj >= b_adj;
  assign room  = cnt < CntW'(MAX_INTERVALS);

  assign s_tready = !busy;
  assign acc      = s_tvalid && s_tready;
  assign start    = acc && s_tlast;

  assign new_ival = '{vld: 1'b1, b: b_adj, e: e_adj};
  assign ctl      = '{ins: acc && room && ok, shift: shift};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= '0;
    end else if (acc && room) begin
      cnt <= cnt + CntW'(1);
    end
  end

  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
    ival_t left_i, right_i;
    logic  left_place_i;
    if (i == 0) begin : g_first
      assign left_i       = '0;
      assign left_place_i = 1'b0;
    end else begin : g_mid
      assign left_i       = ent[i-1];
      assign left_place_i = place[i-1];
    end
    if (i == MAX_INTERVALS - 1) begin : g_last
      assign right_i = '0;
    end else begin : g_inner
      assign right_i = ent[i+1];
    end
    iumrg_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .new_ival   (new_ival),
      .left       (left_i),
      .left_place (left_place_i),
      .right      (right_i),
      .place      (place[i]),
      .ent        (ent[i])
    );
  end

  iumrg_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .head     (ent[0]),
    .shift    (shift),
    .busy     (busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
